### rtl/rdfb_pkg.sv
package rdfb_pkg;

    localparam int unsigned MAX_DIM_DEF = 1024;
    localparam int unsigned ADDR_W      = 20;
    localparam int unsigned PIX_W       = 16;
    localparam int unsigned CFG_W       = 11;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned Q_DEPTH     = 2;

    localparam logic [1:0] SETTLE_CYCLES = 2'd2;
    localparam logic [1:0] BEAT_FIRST    = 2'd0;
    localparam logic [1:0] BEAT_LAST     = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_STRIDE = 3'd0,
        REG_FULL_HEIGHT = 3'd1,
        REG_AREA_HEIGHT = 3'd2,
        REG_SRC_WIDTH   = 3'd3,
        REG_SRC_HEIGHT  = 3'd4,
        REG_DOUBLED     = 3'd5,
        REG_LEFT        = 3'd6,
        REG_FULL_SCREEN = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic doubled;
        logic left;
    } mode_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
        mode_t             mode;
        logic              frame_end;
    } item_t;

endpackage

### rtl/rdfb_cfg.sv
module rdfb_cfg import rdfb_pkg::*; #(
    parameter int unsigned MAX_DIM = MAX_DIM_DEF,
    parameter int unsigned CW      = $clog2(MAX_DIM)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output logic [CFG_W-1:0]     line_stride,
    output mode_t                mode,
    output logic [ADDR_W-1:0]    origin,
    output logic [CW:0]          width,
    output logic [CW:0]          height,
    output logic                 ready
);

    localparam int unsigned WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

    logic [CFG_W-1:0]  line_stride_reg, full_height_reg, area_height_reg;
    logic [CFG_W-1:0]  src_width_reg, src_height_reg;
    logic              doubled_reg, left_reg, full_screen_reg;
    logic [1:0]        settle_reg;
    logic [ADDR_W-1:0] span_reg, span_next;
    logic [ADDR_W-1:0] addend_reg, addend_next;
    logic [ADDR_W-1:0] origin_reg, origin_next;
    logic [CW:0]       width_reg, height_reg;
    logic [CFG_W-1:0]  diff;
    logic [ADDR_W-1:0] offset;
    logic [CFG_W+ADDR_W-1:0] prod;

    function automatic logic [CW:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [WW-1:0] e;
        e = WW'(v);
        if (e == '0) begin
            e = WW'(1);
        end else if (e > WW'(MAX_DIM)) begin
            e = WW'(MAX_DIM);
        end
        return e[CW:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_stride_reg <= CFG_W'(240);
            full_height_reg <= CFG_W'(320);
            area_height_reg <= CFG_W'(320);
            src_width_reg   <= CFG_W'(320);
            src_height_reg  <= CFG_W'(240);
            doubled_reg     <= 1'b0;
            left_reg        <= 1'b0;
            full_screen_reg <= 1'b0;
            settle_reg      <= SETTLE_CYCLES;
        end else begin
            if (cfg_we) begin
                settle_reg <= SETTLE_CYCLES;
                case (cfg_reg_t'(cfg_index))
                    REG_LINE_STRIDE: line_stride_reg <= cfg_wdata;
                    REG_FULL_HEIGHT: full_height_reg <= cfg_wdata;
                    REG_AREA_HEIGHT: area_height_reg <= cfg_wdata;
                    REG_SRC_WIDTH:   src_width_reg   <= cfg_wdata;
                    REG_SRC_HEIGHT:  src_height_reg  <= cfg_wdata;
                    REG_DOUBLED:     doubled_reg     <= cfg_wdata[0];
                    REG_LEFT:        left_reg        <= cfg_wdata[0];
                    REG_FULL_SCREEN: full_screen_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end else if (settle_reg != 2'd0) begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    // origin = stride * span + addend, split over two registered stages
    always_comb begin
        diff = full_height_reg - area_height_reg;
        if (!full_screen_reg && (full_height_reg > area_height_reg)) begin
            offset = ADDR_W'(diff[CFG_W-1:1]);
        end else begin
            offset = '0;
        end
        if (left_reg) begin
            span_next   = offset;
            addend_next = ADDR_W'(line_stride_reg) - ADDR_W'(1);
        end else begin
            span_next   = offset + ADDR_W'(area_height_reg) - ADDR_W'(1);
            addend_next = '0;
        end
    end

    assign prod        = {{ADDR_W{1'b0}}, line_stride_reg} * {{CFG_W{1'b0}}, span_reg};
    assign origin_next = prod[ADDR_W-1:0] + addend_reg;

    always_ff @(posedge aclk) begin
        span_reg   <= span_next;
        addend_reg <= addend_next;
        origin_reg <= origin_next;
        width_reg  <= clamp_dim(src_width_reg);
        height_reg <= clamp_dim(src_height_reg);
    end

    assign line_stride  = line_stride_reg;
    assign mode.doubled = doubled_reg;
    assign mode.left    = left_reg;
    assign origin       = origin_reg;
    assign width        = width_reg;
    assign height       = height_reg;
    assign ready        = (settle_reg == 2'd0);

endmodule

### rtl/rdfb_front.sv
module rdfb_front import rdfb_pkg::*; #(
    parameter int unsigned CW = $clog2(MAX_DIM_DEF)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [PIX_W-1:0]  pixel_value,
    input  logic              frame_start,
    input  logic              cfg_ready,
    input  logic [CFG_W-1:0]  line_stride,
    input  mode_t             mode,
    input  logic [ADDR_W-1:0] origin,
    input  logic [CW:0]       width,
    input  logic [CW:0]       height,
    input  logic              q_full,
    output logic              push,
    output item_t             push_item
);

    logic [CW-1:0]     src_col_reg, src_col_next;
    logic [CW-1:0]     src_row_reg, src_row_next;
    logic [ADDR_W-1:0] lsp_reg, lsp_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [CW-1:0]     col, row;
    logic [ADDR_W-1:0] lsp, p, dx, row_step, col_step;
    logic              row_end, frame_end;

    assign s_tready = cfg_ready && !q_full;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        col = frame_start ? '0 : src_col_reg;
        row = frame_start ? '0 : src_row_reg;
        if ({1'b0, col} >= width) begin
            col = '0;
        end
        if ({1'b0, row} >= height) begin
            row = '0;
        end
        lsp = (col == '0 && row == '0) ? origin : lsp_reg;
        p   = (col == '0) ? lsp : wp_reg;

        dx       = ADDR_W'(line_stride);
        row_step = mode.doubled ? (dx << 1) : dx;
        col_step = mode.doubled ? ADDR_W'(2) : ADDR_W'(1);
        wp_next  = mode.left ? p + row_step : p - row_step;

        row_end   = ({1'b0, col} + (CW+1)'(1)) >= width;
        frame_end = row_end && (({1'b0, row} + (CW+1)'(1)) >= height);

        if (row_end) begin
            src_col_next = '0;
            lsp_next     = mode.left ? lsp - col_step : lsp + col_step;
            src_row_next = frame_end ? '0 : row + CW'(1);
        end else begin
            src_col_next = col + CW'(1);
            lsp_next     = lsp;
            src_row_next = row;
        end

        push_item.addr      = p;
        push_item.pix       = pixel_value;
        push_item.mode      = mode;
        push_item.frame_end = frame_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            lsp_reg     <= '0;
            wp_reg      <= '0;
        end else if (push) begin
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            lsp_reg     <= lsp_next;
            wp_reg      <= wp_next;
        end
    end

endmodule

### rtl/rdfb_queue.sv
module rdfb_queue import rdfb_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    localparam int unsigned PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned NW = $clog2(Q_DEPTH + 1);

    item_t          entry_reg [Q_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]  count_reg;

    assign full       = (count_reg == NW'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + NW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

endmodule

### rtl/rdfb_back.sv
module rdfb_back import rdfb_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   head_valid,
    input  item_t                  head_item,
    input  logic [CFG_W-1:0]       line_stride,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    output logic                   m_tuser
);

    logic [1:0]        beat_reg, beat_next;
    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [PIX_W-1:0]  pix_reg;
    logic              last_reg, frame_last_reg;
    logic              load, last;
    logic [ADDR_W-1:0] dx, col_off, row_off;

    // 2x2 block order: P, P+c, P+c+r, P+r (c, r signed by handedness)
    always_comb begin
        load = head_valid && (!m_valid_reg || m_tready);
        last = !head_item.mode.doubled || (beat_reg == BEAT_LAST);
        pop  = load && last;

        dx      = ADDR_W'(line_stride);
        col_off = head_item.mode.left ? {ADDR_W{1'b1}} : ADDR_W'(1);
        row_off = head_item.mode.left ? dx : -dx;
        case (beat_reg)
            2'd0:    addr_next = head_item.addr;
            2'd1:    addr_next = head_item.addr + col_off;
            2'd2:    addr_next = head_item.addr + col_off + row_off;
            2'd3:    addr_next = head_item.addr + row_off;
            default: addr_next = head_item.addr;
        endcase

        if (load) begin
            beat_next = last ? BEAT_FIRST : beat_reg + 2'd1;
        end else begin
            beat_next = beat_reg;
        end

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg    <= BEAT_FIRST;
            m_valid_reg <= 1'b0;
        end else begin
            beat_reg    <= beat_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            addr_reg       <= addr_next;
            pix_reg        <= head_item.pix;
            last_reg       <= last;
            frame_last_reg <= last && head_item.frame_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - ADDR_W - PIX_W){1'b0}}, pix_reg, addr_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = frame_last_reg;

endmodule

### rtl/rotating_doubling_frame_blitter_core.sv
// Rotating frame blitter: takes RGB565 source pixels in raster order and emits
// frame-buffer writes (pixel index, value) rotated by 90 degrees, right- or
// left-handed, optionally doubled into 2x2 blocks and vertically centered.
// Single mode gives one write per pixel and sustains one pixel per cycle while the
// output is not stalled; doubled mode gives four writes per pixel through the single
// output register. Input is held off after reset and after every register write
// while the frame origin (one 11x20 multiply, two stages) is recomputed. Registers
// are to be written by the user only while the block is idle; the block itself does
// not enforce this. frame_start on s_tuser restarts the source position.
module rotating_doubling_frame_blitter_core import rdfb_pkg::*; #(
    parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] pixel_value
    input  logic                   s_tuser,   // frame_start
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [19:0] write_address, [35:20] write_pixel
    output logic                   m_tlast,   // run_last
    output logic                   m_tuser,   // frame_last
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    localparam int unsigned CW = $clog2(MAX_DIM);

    logic [CFG_W-1:0]  line_stride;
    mode_t             mode;
    logic [ADDR_W-1:0] origin;
    logic [CW:0]       width, height;
    logic              cfg_ready;
    logic              q_full, push, pop, head_valid;
    item_t             push_item, head_item;

    rdfb_cfg #(
        .MAX_DIM (MAX_DIM),
        .CW      (CW)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .line_stride (line_stride),
        .mode        (mode),
        .origin      (origin),
        .width       (width),
        .height      (height),
        .ready       (cfg_ready)
    );

    rdfb_front #(
        .CW (CW)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .pixel_value (s_tdata[PIX_W-1:0]),
        .frame_start (s_tuser),
        .cfg_ready   (cfg_ready),
        .line_stride (line_stride),
        .mode        (mode),
        .origin      (origin),
        .width       (width),
        .height      (height),
        .q_full      (q_full),
        .push        (push),
        .push_item   (push_item)
    );

    rdfb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    rdfb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .line_stride (line_stride),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

### rtl/rdfb_checker.sv
module rdfb_checker import rdfb_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tlast,
    input logic                   m_tuser,
    input logic                   cfg_we
);

    // end of frame is always the last write of its pixel
    a_frame_last_is_run_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame_last without run_last");

    // origin recompute holds off input after a register write
    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_tready)
        else $error("input accepted right after register write");

    a_reset_blocks_input: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled transaction changed");

endmodule

bind rotating_doubling_frame_blitter_core rdfb_checker u_rdfb_checker (.*);

### tb/tb_top.sv
module tb_top;
    import rdfb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ADDR_MASK   = 32'h000F_FFFF;
    localparam int unsigned RANDOM_PIX  = 500;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned PLAN_LEN    = 40;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
        logic              run_last;
        logic              frame_last;
    } fb_write_t;

    typedef struct packed {
        logic              is_cfg;
        cfg_reg_t          reg_id;
        logic [CFG_W-1:0]  value;
        logic [PIX_W-1:0]  pix;
        logic              sof;
        logic              typed;
        logic [ADDR_W-1:0] addr;
        logic              flast;
    } plan_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    rotating_doubling_frame_blitter_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor copy of the register file and blit position
    int unsigned fb_stride = 240;
    int unsigned fb_full_h = 320;
    int unsigned fb_area_h = 320;
    int unsigned img_w     = 320;
    int unsigned img_h     = 240;
    bit          dbl_on    = 1'b0;
    bit          left_on   = 1'b0;
    bit          full_on   = 1'b0;
    int unsigned img_col   = 0;
    int unsigned img_row   = 0;
    int unsigned line_base = 0;
    int unsigned next_addr = 0;

    fb_write_t   pending_writes[$];
    fb_write_t   want;
    int          err_count = 0;
    int unsigned tx_idle = 9;
    int unsigned rx_idle = 72;
    bit          hold_req = 1'b0;

    function automatic void blit_pixel(input logic [PIX_W-1:0] pix, input logic sof);
        int unsigned w, h, n, p, base, step;
        int unsigned a[4];
        bit          row_end, frame_end;
        fb_write_t   wr;
        w = (img_w == 0) ? 1 : ((img_w > MAX_DIM_DEF) ? MAX_DIM_DEF : img_w);
        h = (img_h == 0) ? 1 : ((img_h > MAX_DIM_DEF) ? MAX_DIM_DEF : img_h);
        if (sof) begin
            img_col = 0;
            img_row = 0;
        end
        if (img_col >= w) img_col = 0;
        if (img_row >= h) img_row = 0;
        if (img_col == 0 && img_row == 0) begin
            base = 0;
            if (!full_on && fb_full_h > fb_area_h)
                base = fb_stride * ((fb_full_h - fb_area_h) / 2);
            if (left_on)
                line_base = (base + fb_stride - 1) & ADDR_MASK;
            else
                line_base = (base + fb_stride * (fb_area_h - 1)) & ADDR_MASK;
        end
        if (img_col == 0) next_addr = line_base;
        p = next_addr;
        a[0] = p;
        if (dbl_on) begin
            n = 4;
            if (left_on) begin
                a[1] = p - 1;
                a[2] = p - 1 + fb_stride;
                a[3] = p + fb_stride;
                next_addr = (p + 2 * fb_stride) & ADDR_MASK;
            end else begin
                a[1] = p + 1;
                a[2] = p + 1 - fb_stride;
                a[3] = p - fb_stride;
                next_addr = (p - 2 * fb_stride) & ADDR_MASK;
            end
        end else begin
            n = 1;
            next_addr = (left_on ? p + fb_stride : p - fb_stride) & ADDR_MASK;
        end
        row_end   = (img_col + 1 >= w);
        frame_end = row_end && (img_row + 1 >= h);
        for (int k = 0; k < n; k++) begin
            wr.addr       = a[k][ADDR_W-1:0];
            wr.pix        = pix;
            wr.run_last   = (k + 1 == n);
            wr.frame_last = (k + 1 == n) && frame_end;
            pending_writes.push_back(wr);
        end
        if (row_end) begin
            step      = dbl_on ? 2 : 1;
            img_col   = 0;
            line_base = (left_on ? line_base - step : line_base + step) & ADDR_MASK;
            img_row   = frame_end ? 0 : img_row + 1;
        end else begin
            img_col = img_col + 1;
        end
    endfunction

    // caller is always just past a rising edge; one NBA per signal per step
    task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic sof);
        while ($urandom_range(0, 99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= sof;
        do @(posedge aclk); while (!s_tready);
        blit_pixel(pix, sof);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_W-1:0];
        @(posedge aclk);
        case (idx)
            REG_LINE_STRIDE: fb_stride = val & 32'h7FF;
            REG_FULL_HEIGHT: fb_full_h = val & 32'h7FF;
            REG_AREA_HEIGHT: fb_area_h = val & 32'h7FF;
            REG_SRC_WIDTH:   img_w     = val & 32'h7FF;
            REG_SRC_HEIGHT:  img_h     = val & 32'h7FF;
            REG_DOUBLED:     dbl_on    = val[0];
            REG_LEFT:        left_on   = val[0];
            REG_FULL_SCREEN: full_on   = val[0];
            default: ;
        endcase
        cfg_we <= 1'b0;
    endtask

    function automatic int unsigned pick_size(input bit src_dim);
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 2047;
            2:       return 1024;
            3:       return 1;
            4, 5:    return $urandom_range(0, 2047);
            default: return src_dim ? $urandom_range(1, 6) : $urandom_range(1, 400);
        endcase
    endfunction

    function automatic plan_row_t cfg_row(input cfg_reg_t idx, input int unsigned val);
        plan_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.reg_id = idx;
        r.value  = val[CFG_W-1:0];
        return r;
    endfunction

    function automatic plan_row_t pix_row(input logic [PIX_W-1:0] pix, input logic sof);
        plan_row_t r;
        r     = '0;
        r.pix = pix;
        r.sof = sof;
        return r;
    endfunction

    function automatic plan_row_t chk_row(input logic [PIX_W-1:0] pix, input logic sof,
                                          input int unsigned addr, input logic flast);
        plan_row_t r;
        r       = pix_row(pix, sof);
        r.typed = 1'b1;
        r.addr  = addr[ADDR_W-1:0];
        r.flast = flast;
        return r;
    endfunction

    plan_row_t plan [PLAN_LEN];

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_writes.size() == 0) begin
                err_count++;
                $display("%0t: unexpected transaction addr=%0h pix=%0h",
                         $time, m_tdata[19:0], m_tdata[35:20]);
            end else begin
                want = pending_writes.pop_front();
                if (m_tdata[19:0] !== want.addr) begin
                    err_count++;
                    $display("%0t: write_address expected %0h actual %0h",
                             $time, want.addr, m_tdata[19:0]);
                end
                if (m_tdata[35:20] !== want.pix) begin
                    err_count++;
                    $display("%0t: write_pixel expected %0h actual %0h",
                             $time, want.pix, m_tdata[35:20]);
                end
                if (m_tlast !== want.run_last) begin
                    err_count++;
                    $display("%0t: run_last expected %0b actual %0b",
                             $time, want.run_last, m_tlast);
                end
                if (m_tuser !== want.frame_last) begin
                    err_count++;
                    $display("%0t: frame_last expected %0b actual %0b",
                             $time, want.frame_last, m_tuser);
                end
            end
        end
    end

    initial begin
        int unsigned sent;
        int unsigned burst;
        bit          pressed;
        fb_write_t   typed_wr;
        sent    = 0;
        pressed = 1'b0;
        plan = '{
            // defaults: right-handed single, origin at row 319
            chk_row(16'h0000, 1'b1, 76560, 1'b0),
            chk_row(16'hFFFF, 1'b0, 76320, 1'b0),
            chk_row(16'h8001, 1'b1, 76560, 1'b0),
            cfg_row(REG_SRC_WIDTH, 2),
            cfg_row(REG_SRC_HEIGHT, 2),
            chk_row(16'h1234, 1'b0, 76320, 1'b0),
            chk_row(16'h5A5A, 1'b0, 76561, 1'b0),
            chk_row(16'hA5A5, 1'b0, 76321, 1'b1),
            chk_row(16'h0F0F, 1'b0, 76560, 1'b0),
            cfg_row(REG_DOUBLED, 1),
            pix_row(16'h00FF, 1'b1),
            pix_row(16'hFF00, 1'b0),
            pix_row(16'h7FFF, 1'b0),
            pix_row(16'hC3C3, 1'b0),
            cfg_row(REG_LEFT, 1),
            pix_row(16'h0001, 1'b1),
            pix_row(16'h8000, 1'b0),
            pix_row(16'h3C3C, 1'b0),
            pix_row(16'hFFFE, 1'b0),
            cfg_row(REG_DOUBLED, 0),
            pix_row(16'hAAAA, 1'b1),
            pix_row(16'h5555, 1'b0),
            // zero-height area wraps the address space
            cfg_row(REG_FULL_SCREEN, 1),
            cfg_row(REG_LINE_STRIDE, 1024),
            cfg_row(REG_FULL_HEIGHT, 2047),
            cfg_row(REG_AREA_HEIGHT, 0),
            pix_row(16'h1111, 1'b1),
            pix_row(16'hEEEE, 1'b0),
            cfg_row(REG_FULL_SCREEN, 0),
            cfg_row(REG_LEFT, 0),
            pix_row(16'h2222, 1'b1),
            pix_row(16'hDDDD, 1'b0),
            // source size clamping, area taller than frame
            cfg_row(REG_LINE_STRIDE, 2047),
            cfg_row(REG_SRC_WIDTH, 0),
            cfg_row(REG_SRC_HEIGHT, 2047),
            cfg_row(REG_AREA_HEIGHT, 2047),
            cfg_row(REG_FULL_HEIGHT, 1),
            pix_row(16'h4444, 1'b1),
            pix_row(16'hBBBB, 1'b0),
            pix_row(16'h6666, 1'b0)
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                write_reg(plan[i].reg_id, 32'(plan[i].value));
            end else begin
                push_pixel(plan[i].pix, plan[i].sof);
                if (plan[i].typed) begin
                    typed_wr = '{plan[i].addr, plan[i].pix, 1'b1, plan[i].flast};
                    pending_writes[pending_writes.size() - 1] = typed_wr;
                end
            end
        end

        while (sent < RANDOM_PIX) begin
            for (int r = 0; r < 8; r++) begin
                if ($urandom_range(0, 1)) begin
                    if (r <= int'(REG_SRC_HEIGHT))
                        write_reg(cfg_reg_t'(r),
                                  pick_size(r == int'(REG_SRC_WIDTH) ||
                                            r == int'(REG_SRC_HEIGHT)));
                    else
                        write_reg(cfg_reg_t'(r), $urandom_range(0, 1));
                end
            end
            if (sent >= 2 * RANDOM_PIX / 3) begin
                tx_idle = 0;
                rx_idle = 0;
                if (!pressed) begin
                    hold_req = 1'b1;
                    pressed  = 1'b1;
                end
            end else if (sent >= RANDOM_PIX / 3) begin
                tx_idle = 72;
                rx_idle = 9;
            end
            burst = $urandom_range(5, 40);
            for (int k = 0; k < burst; k++) begin
                push_pixel(PIX_W'($urandom_range(0, 65535)),
                           (k == 0 && $urandom_range(0, 3) != 0) ||
                           ($urandom_range(0, 49) == 0));
                sent++;
            end
        end

        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
